[rtl/core/tfrr_pkg.sv]
// tfrr_pkg: shared types, codes and constants of the task/flag round-robin scheduler
// used by tfrr_pick, tfrr_core and task_flag_round_robin_scheduler; no dependencies
`default_nettype none

package tfrr_pkg;

    localparam int SLOT_COUNT_DEF      = 8;
    localparam int TASKS_PER_ROUND_DEF = 3;

    localparam int DESC_W     = 13;
    localparam int SEL_W      = 16;
    localparam int TR_W       = 16;
    localparam int SLOT_OUT_W = 3;
    localparam int SEL_SHIFT  = 3;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        CMD_NEXT     = 2'd0,
        CMD_EVICT    = 2'd1,
        CMD_CHK_TASK = 2'd2,
        CMD_CHK_FLAG = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_IDX  = 2'd2;

    typedef struct packed {
        logic [DESC_W-1:0] task_base;
        logic [DESC_W-1:0] flag_base;
        logic [DESC_W-1:0] idle_idx;
    } t_cfg;

    typedef struct packed {
        logic [SEL_W-1:0]      selector;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  is_flag;
        logic                  valid_res;
        logic                  evicted;
        logic                  check_ok;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/task_flag_round_robin_scheduler.sv]
// task_flag_round_robin_scheduler: top level, input register, decision, result register
// a command beat goes from the input register through the decision into the result register
// throughput: one command beat per cycle, held back only while the result register stalls
// reset: synchronous active low; all slots alive, counters -1, config and valid bits zero
// depends on tfrr_pkg, tfrr_core, tfrr_pick
`default_nettype none

module task_flag_round_robin_scheduler
    import tfrr_pkg::*;
#(
    parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
    parameter int TASKS_PER_ROUND = TASKS_PER_ROUND_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [DESC_W-1:0]     i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_cmd,
    input  wire logic [TR_W-1:0]       i_tr,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [SEL_W-1:0]           o_selector,
    output logic [SLOT_OUT_W-1:0]      o_slot,
    output logic                       o_is_flag,
    output logic                       o_valid_res,
    output logic                       o_evicted,
    output logic                       o_check_ok
);

    t_cfg            r_cfg;
    logic            r_in_valid;
    t_cmd            r_cmd;
    logic [TR_W-1:0] r_tr;
    logic            r_out_valid;
    t_result         r_res;
    t_result         res;
    logic            out_free;
    logic            step;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TASK_BASE: r_cfg.task_base <= i_cfg_data;
                CFG_FLAG_BASE: r_cfg.flag_base <= i_cfg_data;
                CFG_IDLE_IDX:  r_cfg.idle_idx  <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= t_cmd'(i_cmd);
            r_tr  <= i_tr;
        end
    end

    tfrr_core #(
        .SLOT_COUNT      (SLOT_COUNT),
        .TASKS_PER_ROUND (TASKS_PER_ROUND)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_cmd   (r_cmd),
        .i_tr    (r_tr),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_selector  = r_res.selector;
    assign o_slot      = r_res.slot;
    assign o_is_flag   = r_res.is_flag;
    assign o_valid_res = r_res.valid_res;
    assign o_evicted   = r_res.evicted;
    assign o_check_ok  = r_res.check_ok;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input held back while result register free");

    a_next_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |-> (!o_evicted && !o_check_ok))
        else $error("next result mixed with evict or check");

    a_evict_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted) |-> (o_selector == '0 && !o_check_ok))
        else $error("eviction beat with selector or check pass");

endmodule

`default_nettype wire

[rtl/core/tfrr_pick.sv]
// tfrr_pick: rotating find-first, next live slot after the current one
// depends on tfrr_pkg for the default slot count
`default_nettype none

module tfrr_pick
    import tfrr_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_W     = $clog2(SLOT_COUNT)
) (
    input  wire logic [SLOT_W-1:0]     i_cur,
    input  wire logic [SLOT_COUNT-1:0] i_alive,
    output logic      [SLOT_W-1:0]     o_next
);

    always_comb begin
        logic [SLOT_W:0] c;
        o_next = i_cur;
        c      = '0;
        for (int i = SLOT_COUNT; i >= 1; i--) begin
            c = {1'b0, i_cur} + (SLOT_W+1)'(i);
            if (c >= (SLOT_W+1)'(SLOT_COUNT)) begin
                c = c - (SLOT_W+1)'(SLOT_COUNT);
            end
            if (i_alive[c[SLOT_W-1:0]]) begin
                o_next = c[SLOT_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/tfrr_core.sv]
// tfrr_core: scheduler state and combinational decision for one command beat
// depends on tfrr_pkg and tfrr_pick
`default_nettype none

module tfrr_core
    import tfrr_pkg::*;
#(
    parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
    parameter int TASKS_PER_ROUND = TASKS_PER_ROUND_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire t_cmd            i_cmd,
    input  wire logic [TR_W-1:0] i_tr,
    input  wire t_cfg            i_cfg,
    output t_result              o_res
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int FW     = CW + 2;
    localparam int TW     = $clog2(TASKS_PER_ROUND + 1) + 1;
    localparam int RW     = DESC_W + 1;
    localparam int SXW    = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
    localparam logic signed [TW-1:0] TPR_S = TW'(TASKS_PER_ROUND);

    logic [SLOT_COUNT-1:0] r_alive,     n_alive;
    logic [CW-1:0]         r_alive_cnt, n_alive_cnt;
    logic                  r_phase,     n_phase;
    logic signed [TW-1:0]  r_task_cnt,  n_task_cnt;
    logic signed [FW-1:0]  r_flag_cnt,  n_flag_cnt;
    logic [SLOT_W-1:0]     r_cur_task,  n_cur_task;
    logic [SLOT_W-1:0]     r_cur_flag,  n_cur_flag;

    logic [SLOT_W-1:0] nxt_task, nxt_flag;

    tfrr_pick #(.SLOT_COUNT(SLOT_COUNT), .SLOT_W(SLOT_W)) u_pick_task (
        .i_cur   (r_cur_task),
        .i_alive (r_alive),
        .o_next  (nxt_task)
    );

    tfrr_pick #(.SLOT_COUNT(SLOT_COUNT), .SLOT_W(SLOT_W)) u_pick_flag (
        .i_cur   (r_cur_flag),
        .i_alive (r_alive),
        .o_next  (nxt_flag)
    );

    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [SXW-1:0] ext;
        ext = SXW'(s);
        return ext[SLOT_OUT_W-1:0];
    endfunction

    function automatic logic [SEL_W-1:0] make_sel(input logic [DESC_W-1:0] base,
                                                  input logic [SLOT_W-1:0] s);
        logic [RW-1:0] sum;
        sum = {1'b0, base} + RW'(s);
        return {sum[SEL_W-SEL_SHIFT-1:0], {SEL_SHIFT{1'b0}}};
    endfunction

    function automatic logic in_range(input logic [DESC_W-1:0] idx,
                                      input logic [DESC_W-1:0] base);
        logic [RW-1:0] top;
        top = {1'b0, base} + RW'(SLOT_COUNT - 1);
        return (idx >= base) && ({1'b0, idx} <= top);
    endfunction

    logic [DESC_W-1:0]    idx;
    logic [SLOT_W-1:0]    s_run;
    logic                 can_kill;
    logic signed [FW-1:0] cnt_s;

    assign idx      = i_tr[TR_W-1:SEL_SHIFT];
    assign s_run    = r_phase ? r_cur_flag : r_cur_task;
    assign can_kill = (r_alive_cnt != '0) && r_alive[s_run];
    assign cnt_s    = signed'({2'b00, r_alive_cnt});

    always_comb begin
        logic                 do_evict;
        logic                 pick_flag;
        logic signed [TW-1:0] tc;
        logic signed [FW-1:0] fc;
        n_alive     = r_alive;
        n_alive_cnt = r_alive_cnt;
        n_phase     = r_phase;
        n_task_cnt  = r_task_cnt;
        n_flag_cnt  = r_flag_cnt;
        n_cur_task  = r_cur_task;
        n_cur_flag  = r_cur_flag;
        o_res       = '0;
        do_evict    = 1'b0;
        pick_flag   = 1'b0;
        tc          = r_task_cnt + TW'(1);
        fc          = r_flag_cnt + FW'(1);
        unique case (i_cmd)
            CMD_NEXT: begin
                if (r_alive_cnt != '0) begin
                    if (!r_phase) begin
                        if (tc == TPR_S) begin
                            n_phase    = 1'b1;
                            n_task_cnt = '0;
                            pick_flag  = 1'b1;
                        end else begin
                            n_task_cnt = tc;
                        end
                    end else begin
                        if (fc >= cnt_s) begin
                            n_phase    = 1'b0;
                            n_flag_cnt = '0;
                        end else begin
                            n_flag_cnt = fc;
                            pick_flag  = 1'b1;
                        end
                    end
                    o_res.valid_res = 1'b1;
                    o_res.is_flag   = pick_flag;
                    if (pick_flag) begin
                        n_cur_flag     = nxt_flag;
                        o_res.slot     = slot_out(nxt_flag);
                        o_res.selector = make_sel(i_cfg.flag_base, nxt_flag);
                    end else begin
                        n_cur_task     = nxt_task;
                        o_res.slot     = slot_out(nxt_task);
                        o_res.selector = make_sel(i_cfg.task_base, nxt_task);
                    end
                end
            end
            CMD_EVICT: begin
                do_evict = 1'b1;
            end
            CMD_CHK_TASK: begin
                do_evict = in_range(idx, i_cfg.flag_base) && (idx != i_cfg.idle_idx);
            end
            CMD_CHK_FLAG: begin
                do_evict = in_range(idx, i_cfg.task_base);
            end
            default: begin
                do_evict = 1'b0;
            end
        endcase
        if ((i_cmd == CMD_CHK_TASK || i_cmd == CMD_CHK_FLAG) && !do_evict) begin
            o_res.check_ok = 1'b1;
        end
        if (do_evict) begin
            o_res.slot    = slot_out(s_run);
            o_res.is_flag = r_phase;
            o_res.evicted = can_kill;
            if (can_kill) begin
                n_alive[s_run] = 1'b0;
                n_alive_cnt    = r_alive_cnt - CW'(1);
                if (r_phase && (fc == cnt_s - FW'(1))) begin
                    n_flag_cnt = r_flag_cnt - FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '1;
            r_alive_cnt <= CW'(SLOT_COUNT);
            r_phase     <= 1'b0;
            r_task_cnt  <= '1;
            r_flag_cnt  <= '1;
            r_cur_task  <= SLOT_W'(SLOT_COUNT - 1);
            r_cur_flag  <= SLOT_W'(SLOT_COUNT - 1);
        end else if (i_en) begin
            r_alive     <= n_alive;
            r_alive_cnt <= n_alive_cnt;
            r_phase     <= n_phase;
            r_task_cnt  <= n_task_cnt;
            r_flag_cnt  <= n_flag_cnt;
            r_cur_task  <= n_cur_task;
            r_cur_flag  <= n_cur_flag;
        end
    end

endmodule

`default_nettype wire

[dv/tfrr_sched_checker.sv]
// tfrr_sched_checker: watches the config port and both beat channels of the scheduler,
// predicts each result beat from its own copy of slot state and compares field by field
// depends on tfrr_pkg only
module tfrr_sched_checker
    import tfrr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DESC_W-1:0]     i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_cmd,
    input  logic [TR_W-1:0]       i_tr,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [SEL_W-1:0]      i_selector,
    input  logic [SLOT_OUT_W-1:0] i_slot,
    input  logic                  i_is_flag,
    input  logic                  i_valid_res,
    input  logic                  i_evicted,
    input  logic                  i_check_ok,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_kills
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = SLOT_COUNT_DEF;

    logic [DESC_W-1:0]     task_base;
    logic [DESC_W-1:0]     flag_base;
    logic [DESC_W-1:0]     idle_idx;
    logic [NSLOT-1:0]      alive;
    int                    alive_cnt;
    bit                    flag_phase;
    int                    task_runs;
    int                    flag_runs;
    logic [SLOT_OUT_W-1:0] task_slot;
    logic [SLOT_OUT_W-1:0] flag_slot;

    t_result pending_decisions[$];
    int      fails   = 0;
    int      checked = 0;
    int      kills   = 0;

    function automatic logic [SLOT_OUT_W-1:0] next_live(logic [SLOT_OUT_W-1:0] cur);
        logic [SLOT_OUT_W-1:0] s;
        s = cur;
        for (int i = 0; i < NSLOT; i++) begin
            s = s + 1'b1;
            if (alive[s]) return s;
        end
        return cur;
    endfunction

    function automatic logic [SEL_W-1:0] selector_of(logic [DESC_W-1:0] base,
                                                     logic [SLOT_OUT_W-1:0] s);
        int v;
        v = (int'(base) + int'(s)) << SEL_SHIFT;
        return v[SEL_W-1:0];
    endfunction

    function automatic bit kill_running(output logic [SLOT_OUT_W-1:0] s);
        s = flag_phase ? flag_slot : task_slot;
        if (alive_cnt == 0 || !alive[s]) return 1'b0;
        alive[s] = 1'b0;
        // flag count correction on the second-to-last flag of a phase
        if (flag_phase && flag_runs + 1 == alive_cnt - 1) flag_runs--;
        alive_cnt--;
        kills++;
        return 1'b1;
    endfunction

    function automatic t_result schedule_decision(t_cmd c, logic [TR_W-1:0] t);
        t_result               r;
        logic [SLOT_OUT_W-1:0] s;
        bit                    pick_flag;
        bit                    hit;
        int                    idx;
        r   = '0;
        idx = int'(t >> SEL_SHIFT);
        if (c == CMD_NEXT) begin
            if (alive_cnt == 0) return r;
            if (!flag_phase) begin
                task_runs++;
                pick_flag = (task_runs == TASKS_PER_ROUND_DEF);
                if (pick_flag) begin
                    flag_phase = 1'b1;
                    task_runs  = 0;
                end
            end else begin
                flag_runs++;
                pick_flag = !(flag_runs >= alive_cnt);
                if (!pick_flag) begin
                    flag_phase = 1'b0;
                    flag_runs  = 0;
                end
            end
            if (pick_flag) begin
                flag_slot  = next_live(flag_slot);
                r.selector = selector_of(flag_base, flag_slot);
                r.slot     = flag_slot;
                r.is_flag  = 1'b1;
            end else begin
                task_slot  = next_live(task_slot);
                r.selector = selector_of(task_base, task_slot);
                r.slot     = task_slot;
            end
            r.valid_res = 1'b1;
            return r;
        end
        if (c == CMD_EVICT)
            hit = 1'b1;
        else if (c == CMD_CHK_TASK)
            hit = idx >= flag_base && idx <= flag_base + NSLOT - 1 && idx != idle_idx;
        else
            hit = idx >= task_base && idx <= task_base + NSLOT - 1;
        if (hit) begin
            r.is_flag = flag_phase;
            r.evicted = kill_running(s);
            r.slot    = s;
        end else begin
            r.check_ok = 1'b1;
        end
        return r;
    endfunction

    function automatic bit field_bad(string name, logic [SEL_W-1:0] want,
                                     logic [SEL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            task_base  = '0;
            flag_base  = '0;
            idle_idx   = '0;
            alive      = '1;
            alive_cnt  = NSLOT;
            flag_phase = 1'b0;
            task_runs  = -1;
            flag_runs  = -1;
            task_slot  = SLOT_OUT_W'(NSLOT - 1);
            flag_slot  = SLOT_OUT_W'(NSLOT - 1);
            pending_decisions.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_decisions.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    fails++;
                end else begin
                    want = pending_decisions.pop_front();
                    bad  = field_bad("selector", want.selector, i_selector)
                         | field_bad("slot", SEL_W'(want.slot), SEL_W'(i_slot))
                         | field_bad("is_flag", SEL_W'(want.is_flag), SEL_W'(i_is_flag))
                         | field_bad("valid_res", SEL_W'(want.valid_res),
                                     SEL_W'(i_valid_res))
                         | field_bad("evicted", SEL_W'(want.evicted), SEL_W'(i_evicted))
                         | field_bad("check_ok", SEL_W'(want.check_ok),
                                     SEL_W'(i_check_ok));
                    if (bad) fails++;
                    checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TASK_BASE: task_base = i_cfg_data;
                    CFG_FLAG_BASE: flag_base = i_cfg_data;
                    CFG_IDLE_IDX:  idle_idx  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                pending_decisions.push_back(schedule_decision(t_cmd'(i_cmd), i_tr));
        end
        o_pending    <= pending_decisions.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_kills      <= kills;
    end

endmodule

[dv/testbench.sv]
// testbench: drives commands and register settings into the scheduler with random gaps
// and stalls, and gives the verdict from the failure and pending counts of tfrr_sched_checker
// depends on tfrr_pkg, task_flag_round_robin_scheduler and tfrr_sched_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tfrr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int NUM_PHASES      = 5;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int LONG_HOLD_AT    = 330;
    localparam int LONG_HOLD_LEN   = 120;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DESC_W-1:0]     i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic [1:0]            i_cmd       = CMD_NEXT;
    logic [TR_W-1:0]       i_tr        = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [SEL_W-1:0]      o_selector;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic                  o_is_flag;
    logic                  o_valid_res;
    logic                  o_evicted;
    logic                  o_check_ok;

    int fail_count;
    int pending;
    int checked;
    int kills;
    int cycle_count = 0;
    int sent        = 0;
    int settings    = 0;
    int burst_left  = 0;
    bit long_done   = 1'b0;

    logic [DESC_W-1:0] cur_task_base = '0;
    logic [DESC_W-1:0] cur_flag_base = '0;
    logic [DESC_W-1:0] cur_idle      = '0;

    task_flag_round_robin_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_tr        (i_tr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_selector  (o_selector),
        .o_slot      (o_slot),
        .o_is_flag   (o_is_flag),
        .o_valid_res (o_valid_res),
        .o_evicted   (o_evicted),
        .o_check_ok  (o_check_ok)
    );

    tfrr_sched_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_tr         (i_tr),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_selector   (o_selector),
        .i_slot       (o_slot),
        .i_is_flag    (o_is_flag),
        .i_valid_res  (o_valid_res),
        .i_evicted    (o_evicted),
        .i_check_ok   (o_check_ok),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_kills      (kills)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("** task_flag_round_robin_scheduler: FAILED **");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int r;
        int n;
        wait (i_rst_n);
        forever begin
            if (!long_done && checked >= LONG_HOLD_AT) begin
                long_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_LEN) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_out_ready <= 1'b1;
                    n = $urandom_range(1, 20);
                end else if (r < 95) begin
                    i_out_ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_ready <= 1'b0;
                    n = $urandom_range(10, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input logic [TR_W-1:0] t);
        int gap;
        int r;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                burst_left = $urandom_range(20, 40);
                gap = 0;
            end else if (r < 55) begin
                gap = 0;
            end else if (r < 88) begin
                gap = $urandom_range(1, 3);
            end else if (r < 97) begin
                gap = $urandom_range(4, 10);
            end else begin
                gap = $urandom_range(20, 50);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_tr       <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    // stop sending and let every outstanding result beat drain
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [DESC_W-1:0] tb, input logic [DESC_W-1:0] fb,
                                input logic [DESC_W-1:0] idle);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TASK_BASE;
        i_cfg_data  <= tb;
        @(posedge i_clk);
        i_cfg_index <= CFG_FLAG_BASE;
        i_cfg_data  <= fb;
        @(posedge i_clk);
        i_cfg_index <= CFG_IDLE_IDX;
        i_cfg_data  <= idle;
        @(posedge i_clk);
        // unmapped index must be ignored
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= DESC_W'($urandom_range(0, 8191));
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        cur_task_base = tb;
        cur_flag_base = fb;
        cur_idle      = idle;
        settings++;
    endtask

    initial begin : stimulus
        t_cmd              c;
        logic [DESC_W-1:0] other;
        logic [DESC_W-1:0] idx;
        logic [DESC_W-1:0] tb;
        logic [DESC_W-1:0] fb;
        logic [TR_W-1:0]   t;
        int                r;
        int                q;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_config('0, '0, '0);

        // evict before any next, then on the dead slot
        send_cmd(CMD_EVICT, 16'h0000);
        send_cmd(CMD_EVICT, 16'hFFFF);
        // first round, up to the second-to-last flag
        repeat (10) send_cmd(CMD_NEXT, TR_W'($urandom));
        // evict there to hit the flag count correction
        send_cmd(CMD_EVICT, TR_W'($urandom));
        repeat (2) send_cmd(CMD_NEXT, TR_W'($urandom));
        send_cmd(CMD_CHK_TASK, 16'h0000);
        send_cmd(CMD_CHK_TASK, 16'h0007);
        send_cmd(CMD_CHK_FLAG, 16'hFFFF);
        send_cmd(CMD_CHK_TASK, 16'h0008);
        send_cmd(CMD_CHK_FLAG, 16'h0038);
        send_cmd(CMD_CHK_TASK, 16'hFFFF);
        send_cmd(CMD_CHK_FLAG, 16'h0040);
        send_cmd(CMD_NEXT, 16'h0000);

        for (int p = 1; p <= NUM_PHASES; p++) begin
            drain();
            case (p)
                1: write_config(13'd8184, 13'd8184, 13'd8191);
                2: begin
                    fb = DESC_W'($urandom_range(0, 8184));
                    tb = DESC_W'($urandom_range(0, 8184));
                    write_config(tb, fb, fb + DESC_W'($urandom_range(0, 7)));
                end
                3: write_config(13'd0, 13'd8, 13'd8);
                4: write_config(DESC_W'($urandom_range(0, 8184)),
                                DESC_W'($urandom_range(0, 8184)),
                                DESC_W'($urandom_range(0, 8191)));
                default: begin
                    tb = DESC_W'($urandom_range(0, 8184));
                    write_config(tb, tb, DESC_W'($urandom_range(0, 8191)));
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 999);
                if (r < 3)
                    c = CMD_EVICT;
                else if (r < 600)
                    c = CMD_NEXT;
                else if (r < 800)
                    c = CMD_CHK_TASK;
                else
                    c = CMD_CHK_FLAG;
                t = TR_W'($urandom_range(0, 65535));
                if (c == CMD_CHK_TASK || c == CMD_CHK_FLAG) begin
                    other = (c == CMD_CHK_TASK) ? cur_flag_base : cur_task_base;
                    q = $urandom_range(0, 99);
                    if (q < 70)
                        idx = t[TR_W-1:SEL_SHIFT];
                    else if (q < 80)
                        idx = other - DESC_W'(1);
                    else if (q < 90)
                        idx = other + DESC_W'(8);
                    else if (q < 99)
                        idx = cur_idle;
                    else
                        idx = other + DESC_W'($urandom_range(0, 7));
                    t = {idx, t[SEL_SHIFT-1:0]};
                end
                send_cmd(c, t);
            end
        end

        // kill every slot, then run with nothing alive
        repeat (20) begin
            send_cmd(CMD_NEXT, TR_W'($urandom));
            send_cmd(CMD_EVICT, TR_W'($urandom));
        end
        repeat (3) send_cmd(CMD_NEXT, TR_W'($urandom));
        send_cmd(CMD_CHK_FLAG, {cur_task_base, 3'b101});
        send_cmd(CMD_CHK_TASK, {cur_flag_base + 13'd1, 3'b010});
        send_cmd(CMD_EVICT, 16'h0000);
        send_cmd(CMD_NEXT, 16'hFFFF);

        drain();
        repeat (10) @(posedge i_clk);
        $display("run covered %0d command beats under %0d register settings, %0d results checked",
                 sent, settings, checked);
        $display("%0d slots killed, result side held off %0d cycles once", kills, LONG_HOLD_LEN);
        if (fail_count == 0 && pending == 0)
            $display("** task_flag_round_robin_scheduler: PASSED **");
        else
            $display("** task_flag_round_robin_scheduler: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/core/tfrr_pkg.sv
rtl/core/tfrr_pick.sv
rtl/core/tfrr_core.sv
rtl/core/task_flag_round_robin_scheduler.sv
dv/tfrr_sched_checker.sv
dv/testbench.sv
